// ----- design/gaio_pkg.sv -----
// ----------------------------------------------------------------------------
// gaio_pkg
// Shared widths, register indexes and the configuration bundle of the grid
// array item offset block.
// ----------------------------------------------------------------------------
package gaio_pkg;

    localparam int IDX_W   = 20;   // item index
    localparam int DIM_W   = 11;   // columns / rows
    localparam int DAT_W   = 32;   // pitch, skew, offsets
    localparam int STG_W   = 10;   // stagger
    localparam int MODE_W  = 4;
    localparam int ADDR_W  = 3;
    localparam int MUL_W   = 53;   // 21 bit coordinate times 32 bit step
    localparam int PSUM_W  = 54;
    localparam int SUM_W   = 56;
    localparam int CEN_W   = 46;
    localparam int SNUM_W  = 42;   // rounded stagger numerator
    localparam int SPRD_W  = 41;

    typedef enum logic [ADDR_W-1:0] {
        REG_COLUMNS = 3'd0,
        REG_ROWS    = 3'd1,
        REG_PITCH_X = 3'd2,
        REG_PITCH_Y = 3'd3,
        REG_SKEW_X  = 3'd4,
        REG_SKEW_Y  = 3'd5,
        REG_STAGGER = 3'd6,
        REG_MODE    = 3'd7
    } gaio_reg_t;

    localparam int MODE_HORIZ   = 0;
    localparam int MODE_SERP    = 1;
    localparam int MODE_SROWS   = 2;
    localparam int MODE_CENTRED = 3;

    typedef struct packed {
        logic [DIM_W-1:0]        axis;
        logic                    horiz;
        logic                    serp;
        logic                    srows;
        logic                    centred;
        logic                    stag_en;
        logic                    stag_neg;
        logic [STG_W-1:0]        stag_s;
        logic signed [DAT_W-1:0] px;
        logic signed [DAT_W-1:0] py;
        logic signed [DAT_W-1:0] kx;
        logic signed [DAT_W-1:0] ky;
        logic [DAT_W-1:0]        abs_px;
        logic [DAT_W-1:0]        abs_py;
        logic [DAT_W-1:0]        abs_kx;
        logic [DAT_W-1:0]        abs_ky;
        logic signed [CEN_W-1:0] cen_x;
        logic signed [CEN_W-1:0] cen_y;
    } gaio_cfg_t;

endpackage

// ----- design/gaio_cfg.sv -----
// ----------------------------------------------------------------------------
// gaio_cfg
// Configuration registers, clamping of dimensions and stagger, and the
// registered centring shifts derived from them.
// ----------------------------------------------------------------------------
module gaio_cfg import gaio_pkg::*; #(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_STAGGER = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [ADDR_W-1:0] cfg_index,
    input  logic [DAT_W-1:0]  cfg_wdata,
    output gaio_cfg_t         cfg
);

    logic [DIM_W-1:0]        columns_reg;
    logic [DIM_W-1:0]        rows_reg;
    logic [DAT_W-1:0]        pitch_x_reg;
    logic [DAT_W-1:0]        pitch_y_reg;
    logic [DAT_W-1:0]        skew_x_reg;
    logic [DAT_W-1:0]        skew_y_reg;
    logic [STG_W-1:0]        stagger_reg;
    logic [MODE_W-1:0]       mode_reg;

    logic [DIM_W-1:0]        nx;
    logic [DIM_W-1:0]        ny;
    logic [STG_W-1:0]        st_mag;
    logic [STG_W-1:0]        st_s;

    logic signed [DIM_W+DAT_W:0]   exa_reg, exb_reg, eya_reg, eyb_reg;
    logic signed [DIM_W+DAT_W+1:0] ex_next, ey_next;
    logic [CEN_W-1:0]              exm_reg, eym_reg;
    logic                          exn_reg, eyn_reg;
    logic [CEN_W-1:0]              hx, hy;
    logic signed [CEN_W-1:0]       cen_x_reg, cen_y_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
        if (raw == '0) begin
            return DIM_W'(1);
        end else if (32'(raw) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return raw;
    endfunction

    function automatic logic [DAT_W-1:0] abs32(input logic [DAT_W-1:0] v);
        return v[DAT_W-1] ? (~v + DAT_W'(1)) : v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= DIM_W'(1);
            rows_reg    <= DIM_W'(1);
            pitch_x_reg <= '0;
            pitch_y_reg <= '0;
            skew_x_reg  <= '0;
            skew_y_reg  <= '0;
            stagger_reg <= '0;
            mode_reg    <= MODE_W'(1);
        end else if (cfg_wen) begin
            unique case (gaio_reg_t'(cfg_index))
                REG_COLUMNS: columns_reg <= cfg_wdata[DIM_W-1:0];
                REG_ROWS:    rows_reg    <= cfg_wdata[DIM_W-1:0];
                REG_PITCH_X: pitch_x_reg <= cfg_wdata;
                REG_PITCH_Y: pitch_y_reg <= cfg_wdata;
                REG_SKEW_X:  skew_x_reg  <= cfg_wdata;
                REG_SKEW_Y:  skew_y_reg  <= cfg_wdata;
                REG_STAGGER: stagger_reg <= cfg_wdata[STG_W-1:0];
                REG_MODE:    mode_reg    <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign nx     = clamp_dim(columns_reg);
    assign ny     = clamp_dim(rows_reg);
    assign st_mag = stagger_reg[STG_W-1] ? (~stagger_reg + STG_W'(1)) : stagger_reg;
    assign st_s   = (32'(st_mag) > MAX_STAGGER) ? STG_W'(MAX_STAGGER) : st_mag;

    // centring shifts, recomputed every cycle from the registers
    assign ex_next = (DIM_W+DAT_W+2)'(exa_reg) + (DIM_W+DAT_W+2)'(exb_reg);
    assign ey_next = (DIM_W+DAT_W+2)'(eya_reg) + (DIM_W+DAT_W+2)'(eyb_reg);
    assign hx = (exm_reg + CEN_W'(1)) >> 1;
    assign hy = (eym_reg + CEN_W'(1)) >> 1;

    always_ff @(posedge aclk) begin
        exa_reg   <= $signed({1'b0, nx - DIM_W'(1)}) * $signed(pitch_x_reg);
        exb_reg   <= $signed({1'b0, ny - DIM_W'(1)}) * $signed(skew_x_reg);
        eya_reg   <= $signed({1'b0, ny - DIM_W'(1)}) * $signed(pitch_y_reg);
        eyb_reg   <= $signed({1'b0, nx - DIM_W'(1)}) * $signed(skew_y_reg);
        exn_reg   <= ex_next[DIM_W+DAT_W+1];
        eyn_reg   <= ey_next[DIM_W+DAT_W+1];
        exm_reg   <= ex_next[DIM_W+DAT_W+1] ? CEN_W'(-ex_next) : CEN_W'(ex_next);
        eym_reg   <= ey_next[DIM_W+DAT_W+1] ? CEN_W'(-ey_next) : CEN_W'(ey_next);
        cen_x_reg <= exn_reg ? -$signed(hx) : $signed(hx);
        cen_y_reg <= eyn_reg ? -$signed(hy) : $signed(hy);
    end

    always_comb begin
        cfg          = '0;
        cfg.horiz    = mode_reg[MODE_HORIZ];
        cfg.serp     = mode_reg[MODE_SERP];
        cfg.srows    = mode_reg[MODE_SROWS];
        cfg.centred  = mode_reg[MODE_CENTRED];
        cfg.axis     = mode_reg[MODE_HORIZ] ? nx : ny;
        cfg.stag_s   = st_s;
        cfg.stag_en  = st_s > STG_W'(1);
        cfg.stag_neg = stagger_reg[STG_W-1];
        cfg.px       = $signed(pitch_x_reg);
        cfg.py       = $signed(pitch_y_reg);
        cfg.kx       = $signed(skew_x_reg);
        cfg.ky       = $signed(skew_y_reg);
        cfg.abs_px   = abs32(pitch_x_reg);
        cfg.abs_py   = abs32(pitch_y_reg);
        cfg.abs_kx   = abs32(skew_x_reg);
        cfg.abs_ky   = abs32(skew_y_reg);
        cfg.cen_x    = cen_x_reg;
        cfg.cen_y    = cen_y_reg;
    end

endmodule

// ----- design/gaio_div.sv -----
// ----------------------------------------------------------------------------
// gaio_div
// Pipelined unsigned restoring divider, STEP quotient bits per stage, with a
// side word carried along so the caller's data stays aligned.
// ----------------------------------------------------------------------------
module gaio_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 11,
    parameter int STEP  = 4,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [DEN_W-1:0] out_rem,
    output logic [TAG_W-1:0] out_tag
);

    localparam int STAGES = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W  = STAGES * STEP;

    logic             valid_reg [STAGES];
    logic [PAD_W-1:0] work_reg  [STAGES];
    logic [DEN_W-1:0] rem_reg   [STAGES];
    logic [DEN_W-1:0] den_reg   [STAGES];
    logic [TAG_W-1:0] tag_reg   [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic             v_in;
        logic [PAD_W-1:0] w_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [TAG_W-1:0] t_in;
        logic [PAD_W-1:0] work_next;
        logic [DEN_W-1:0] rem_next;

        if (g == 0) begin : g_first
            assign v_in = in_valid;
            assign w_in = PAD_W'(in_num);
            assign r_in = '0;
            assign d_in = in_den;
            assign t_in = in_tag;
        end else begin : g_rest
            assign v_in = valid_reg[g-1];
            assign w_in = work_reg[g-1];
            assign r_in = rem_reg[g-1];
            assign d_in = den_reg[g-1];
            assign t_in = tag_reg[g-1];
        end

        always_comb begin
            logic [DEN_W:0]   t;
            logic [PAD_W-1:0] w;
            logic [DEN_W-1:0] r;
            w = w_in;
            r = r_in;
            for (int b = 0; b < STEP; b++) begin
                t = {r, w[PAD_W-1]};
                w = {w[PAD_W-2:0], 1'b0};
                if (t >= {1'b0, d_in}) begin
                    t    = t - {1'b0, d_in};
                    w[0] = 1'b1;
                end
                r = t[DEN_W-1:0];
            end
            work_next = w;
            rem_next  = r;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[g] <= work_next;
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= d_in;
                tag_reg[g]  <= t_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = work_reg[STAGES-1][NUM_W-1:0];
    assign out_rem   = rem_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ----- design/grid_array_item_offset.sv -----
// ----------------------------------------------------------------------------
// grid_array_item_offset
// Maps an item index to its saturated 2D offset from item 0 of a grid, or from the grid centre in centred mode.
// ----------------------------------------------------------------------------
//  channel   ports                             dir   handshake
//  input     s_item_index                      in    s_valid / s_ready
//  result    m_offset_x, m_offset_y            out   m_valid / m_ready
//  config    cfg_index, cfg_wdata              in    cfg_wen
//
//  one word per cycle sustained while the output is not stalled; words pass
//  through the three divider pipelines (index split 5 stages,
//  stagger modulo 5 stages, rounded stagger quotient 7 stages)
//  the whole pipeline holds while m_valid is high and m_ready is low
//  synchronous active-low reset clears all valid bits; the centring shifts
//  settle through their product, magnitude and shift registers after a register write
// ----------------------------------------------------------------------------
module grid_array_item_offset import gaio_pkg::*; #(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_STAGGER = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [ADDR_W-1:0]       cfg_index,
    input  logic [DAT_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IDX_W-1:0]        s_item_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DAT_W-1:0] m_offset_x,
    output logic signed [DAT_W-1:0] m_offset_y
);

    gaio_cfg_t cfg;
    logic      en;

    // index split
    logic             a_valid;
    logic [IDX_W-1:0] a_quo;
    logic [DIM_W-1:0] a_rem;
    logic [DIM_W-1:0] p_flip;

    logic             c1_valid_reg;
    logic [IDX_W-1:0] cx_reg, cy_reg;

    // stagger modulo
    logic               b_valid;
    logic [STG_W-1:0]   b_rem;
    logic [2*IDX_W-1:0] b_tag;
    logic [IDX_W-1:0]   b_cx, b_cy;

    // products
    logic                    m1_valid_reg;
    logic signed [MUL_W-1:0] ax_reg, bx_reg, ay_reg, by_reg;
    logic [SPRD_W-1:0]       pkx_reg, pky_reg;
    logic                    sgx_reg, sgy_reg;
    logic [DAT_W-1:0]        abs_dx, abs_dy;
    logic                    sgn_dx, sgn_dy;

    logic                     m2_valid_reg;
    logic signed [PSUM_W-1:0] sumx_reg, sumy_reg;
    logic [SNUM_W-1:0]        numx_reg, numy_reg;
    logic                     nsgx_reg, nsgy_reg;

    // rounded stagger quotient
    logic                  cx_valid;
    logic [SNUM_W-1:0]     qx, qy;
    logic [2*PSUM_W:0]     cx_tag;
    logic                  cy_sgn;
    logic                  qx_sgn;
    logic signed [PSUM_W-1:0] fsumx, fsumy;
    logic signed [DAT_W:0]    stx, sty;

    logic                    f1_valid_reg;
    logic signed [SUM_W-1:0] fx_reg, fy_reg;

    logic                    m_valid_reg;
    logic signed [DAT_W-1:0] off_x_reg, off_y_reg;

    function automatic logic [DAT_W-1:0] sat32(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:DAT_W-1] == '0 || v[SUM_W-1:DAT_W-1] == '1) begin
            return v[DAT_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(DAT_W-1){1'b0}}} : {1'b0, {(DAT_W-1){1'b1}}};
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    gaio_cfg #(
        .MAX_DIM     (MAX_DIM),
        .MAX_STAGGER (MAX_STAGGER)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gaio_div #(
        .NUM_W (IDX_W),
        .DEN_W (DIM_W),
        .STEP  (4),
        .TAG_W (1)
    ) u_div_idx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_num    (s_item_index),
        .in_den    (cfg.axis),
        .in_tag    (1'b0),
        .out_valid (a_valid),
        .out_quo   (a_quo),
        .out_rem   (a_rem),
        .out_tag   ()
    );

    // serpentine: odd lines run backwards
    assign p_flip = (cfg.serp && a_quo[0]) ? (cfg.axis - DIM_W'(1) - a_rem) : a_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
        end else if (en) begin
            c1_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= cfg.horiz ? IDX_W'(p_flip) : a_quo;
            cy_reg <= cfg.horiz ? a_quo : IDX_W'(p_flip);
        end
    end

    gaio_div #(
        .NUM_W (IDX_W),
        .DEN_W (STG_W),
        .STEP  (4),
        .TAG_W (2*IDX_W)
    ) u_div_stg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c1_valid_reg),
        .in_num    (cfg.srows ? cy_reg : cx_reg),
        .in_den    (cfg.stag_s),
        .in_tag    ({cx_reg, cy_reg}),
        .out_valid (b_valid),
        .out_quo   (),
        .out_rem   (b_rem),
        .out_tag   (b_tag)
    );

    assign b_cx   = b_tag[2*IDX_W-1:IDX_W];
    assign b_cy   = b_tag[IDX_W-1:0];
    assign abs_dx = cfg.srows ? cfg.abs_px : cfg.abs_kx;
    assign abs_dy = cfg.srows ? cfg.abs_ky : cfg.abs_py;
    assign sgn_dx = cfg.srows ? cfg.px[DAT_W-1] : cfg.kx[DAT_W-1];
    assign sgn_dy = cfg.srows ? cfg.ky[DAT_W-1] : cfg.py[DAT_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= b_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg   <= $signed({1'b0, b_cx}) * cfg.px;
            bx_reg   <= $signed({1'b0, b_cy}) * cfg.kx;
            ay_reg   <= $signed({1'b0, b_cy}) * cfg.py;
            by_reg   <= $signed({1'b0, b_cx}) * cfg.ky;
            pkx_reg  <= SPRD_W'(abs_dx) * SPRD_W'(b_rem);
            pky_reg  <= SPRD_W'(abs_dy) * SPRD_W'(b_rem);
            sgx_reg  <= sgn_dx ^ cfg.stag_neg;
            sgy_reg  <= sgn_dy ^ cfg.stag_neg;
            sumx_reg <= PSUM_W'(ax_reg) + PSUM_W'(bx_reg);
            sumy_reg <= PSUM_W'(ay_reg) + PSUM_W'(by_reg);
            // half away from zero: (2|v| + s) / 2s
            numx_reg <= {pkx_reg, 1'b0} + SNUM_W'(cfg.stag_s);
            numy_reg <= {pky_reg, 1'b0} + SNUM_W'(cfg.stag_s);
            nsgx_reg <= sgx_reg;
            nsgy_reg <= sgy_reg;
        end
    end

    gaio_div #(
        .NUM_W (SNUM_W),
        .DEN_W (STG_W+1),
        .STEP  (6),
        .TAG_W (2*PSUM_W+1)
    ) u_div_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .in_num    (numx_reg),
        .in_den    ({cfg.stag_s, 1'b0}),
        .in_tag    ({nsgx_reg, sumx_reg, sumy_reg}),
        .out_valid (cx_valid),
        .out_quo   (qx),
        .out_rem   (),
        .out_tag   (cx_tag)
    );

    gaio_div #(
        .NUM_W (SNUM_W),
        .DEN_W (STG_W+1),
        .STEP  (6),
        .TAG_W (1)
    ) u_div_ry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .in_num    (numy_reg),
        .in_den    ({cfg.stag_s, 1'b0}),
        .in_tag    (nsgy_reg),
        .out_valid (),
        .out_quo   (qy),
        .out_rem   (),
        .out_tag   (cy_sgn)
    );

    assign qx_sgn = cx_tag[2*PSUM_W];
    assign fsumx  = $signed(cx_tag[2*PSUM_W-1:PSUM_W]);
    assign fsumy  = $signed(cx_tag[PSUM_W-1:0]);

    always_comb begin
        stx = '0;
        sty = '0;
        if (cfg.stag_en) begin
            stx = qx_sgn ? -$signed({1'b0, qx[DAT_W-1:0]}) : $signed({1'b0, qx[DAT_W-1:0]});
            sty = cy_sgn ? -$signed({1'b0, qy[DAT_W-1:0]}) : $signed({1'b0, qy[DAT_W-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= cx_valid;
            m_valid_reg  <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg    <= SUM_W'(fsumx) + SUM_W'(stx)
                         - (cfg.centred ? SUM_W'(cfg.cen_x) : SUM_W'(0));
            fy_reg    <= SUM_W'(fsumy) + SUM_W'(sty)
                         - (cfg.centred ? SUM_W'(cfg.cen_y) : SUM_W'(0));
            off_x_reg <= $signed(sat32(fx_reg));
            off_y_reg <= $signed(sat32(fy_reg));
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_offset_x = off_x_reg;
    assign m_offset_y = off_y_reg;

endmodule

// ----- design/gaio_chk.sv -----
// ----------------------------------------------------------------------------
// gaio_chk
// Port-level checks of the grid array item offset block, bound to its top.
// ----------------------------------------------------------------------------
module gaio_chk import gaio_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [DAT_W-1:0] m_offset_x,
    input logic signed [DAT_W-1:0] m_offset_y
);

    // a held result word keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_offset_x) && $stable(m_offset_y))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // empty output stage never blocks the input
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // a stalled output freezes the whole pipeline
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // handshake outputs are always driven out of reset
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({m_valid, s_ready}))
        else $error("unknown handshake output");

endmodule

bind grid_array_item_offset gaio_chk u_gaio_chk (.*);

// ----- tb/tb_grid_array_item_offset.sv -----
// ----------------------------------------------------------------------------
// tb_grid_array_item_offset
// Self-checking bench for the grid array item offset block. Registers are
// set per phase while the block is idle, index words are streamed with random
// gaps and back-pressure, and each offset is checked against a behavioral
// model of the grid arithmetic kept inside the bench.
// ----------------------------------------------------------------------------
module tb_grid_array_item_offset;
    import gaio_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int MAX_DIM_TB     = 1024;
    localparam int MAX_STG_TB     = 256;

    typedef struct {
        logic signed [DAT_W-1:0] x;
        logic signed [DAT_W-1:0] y;
    } offset_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wen;
    logic [ADDR_W-1:0]       cfg_index;
    logic [DAT_W-1:0]        cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [IDX_W-1:0]        s_item_index;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [DAT_W-1:0] m_offset_x;
    logic signed [DAT_W-1:0] m_offset_y;

    grid_array_item_offset dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item_index(s_item_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_offset_x(m_offset_x), .m_offset_y(m_offset_y)
    );

    // shadow of the register file
    logic [DIM_W-1:0]  sh_columns, sh_rows;
    logic [DAT_W-1:0]  sh_pitch_x, sh_pitch_y, sh_skew_x, sh_skew_y;
    logic [STG_W-1:0]  sh_stagger;
    logic [MODE_W-1:0] sh_mode;

    offset_t pending_offsets[$];
    int      errors = 0;
    int      words_sent;
    int      words_checked = 0;
    int      phases_run;
    bit      steady;        // no idling on either side
    bit      hold_req;
    int      hold_cnt;
    int      quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint dim_clamp(logic [DIM_W-1:0] raw);
        longint d;
        d = raw;
        if (d < 1) d = 1;
        if (d > MAX_DIM_TB) d = MAX_DIM_TB;
        return d;
    endfunction

    function automatic longint round_div(longint num, longint d);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + d) / (d * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [DAT_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[DAT_W-1:0];
    endfunction

    function automatic offset_t grid_offset(logic [IDX_W-1:0] idx);
        longint n, nx, ny, px, py, kx, ky, st, s, axis, p, l, cx, cy, x, y, k;
        longint ex, ey;
        offset_t r;
        bit horiz, serp, srows, centred;
        n  = idx;
        nx = dim_clamp(sh_columns);
        ny = dim_clamp(sh_rows);
        px = longint'($signed(sh_pitch_x));
        py = longint'($signed(sh_pitch_y));
        kx = longint'($signed(sh_skew_x));
        ky = longint'($signed(sh_skew_y));
        st = longint'($signed(sh_stagger));
        horiz   = sh_mode[MODE_HORIZ];
        serp    = sh_mode[MODE_SERP];
        srows   = sh_mode[MODE_SROWS];
        centred = sh_mode[MODE_CENTRED];
        axis = horiz ? nx : ny;
        p = n % axis;
        l = n / axis;
        if (serp && l[0]) p = axis - p - 1;
        if (horiz) begin
            cx = p; cy = l;
        end else begin
            cx = l; cy = p;
        end
        x = cx * px + cy * kx;
        y = cy * py + cx * ky;
        s = (st < 0) ? -st : st;
        if (s > MAX_STG_TB) s = MAX_STG_TB;
        if (s > 1) begin
            k = (srows ? cy : cx) % s;
            if (st < 0) k = -k;
            x += round_div((srows ? px : kx) * k, s);
            y += round_div((srows ? ky : py) * k, s);
        end
        if (centred) begin
            ex = (nx - 1) * px + (ny - 1) * kx;
            ey = (ny - 1) * py + (nx - 1) * ky;
            x -= round_div(ex, 2);
            y -= round_div(ey, 2);
        end
        r.x = clip32(x);
        r.y = clip32(y);
        return r;
    endfunction

    task automatic write_reg(gaio_reg_t r, logic [DAT_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        case (r)
            REG_COLUMNS: sh_columns = v[DIM_W-1:0];
            REG_ROWS:    sh_rows    = v[DIM_W-1:0];
            REG_PITCH_X: sh_pitch_x = v;
            REG_PITCH_Y: sh_pitch_y = v;
            REG_SKEW_X:  sh_skew_x  = v;
            REG_SKEW_Y:  sh_skew_y  = v;
            REG_STAGGER: sh_stagger = v[STG_W-1:0];
            REG_MODE:    sh_mode    = v[MODE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic load_grid(logic [DAT_W-1:0] cols, logic [DAT_W-1:0] rws,
                             logic [DAT_W-1:0] pxv, logic [DAT_W-1:0] pyv,
                             logic [DAT_W-1:0] kxv, logic [DAT_W-1:0] kyv,
                             logic [DAT_W-1:0] stg, logic [DAT_W-1:0] mode);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rws);
        write_reg(REG_PITCH_X, pxv);
        write_reg(REG_PITCH_Y, pyv);
        write_reg(REG_SKEW_X, kxv);
        write_reg(REG_SKEW_Y, kyv);
        write_reg(REG_STAGGER, stg);
        write_reg(REG_MODE, mode);
        // wait for the centring terms to settle after the last write
        repeat (4) @(posedge aclk);
        phases_run++;
    endtask

    // one index word; valid stays high afterwards for a following word
    task automatic send_index(logic [IDX_W-1:0] idx);
        if (!steady && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_item_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_offsets.push_back(grid_offset(idx));
        words_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DAT_W-1:0] pick_step();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(200) - 100;
            4: return $urandom_range(2000000) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int span;
        span = int'(dim_clamp(sh_columns) * dim_clamp(sh_rows));
        case ($urandom_range(9))
            0: return IDX_W'($urandom);
            1: return {IDX_W{1'b1}};
            2: return '0;
            default: return IDX_W'($urandom_range(span - 1));
        endcase
    endfunction

    task automatic test_reset_defaults;
        sh_columns = 1; sh_rows = 1; sh_mode = 4'd1;
        sh_pitch_x = 0; sh_pitch_y = 0; sh_skew_x = 0; sh_skew_y = 0;
        sh_stagger = 0;
        send_index(0);
        send_index(1);
        send_index({IDX_W{1'b1}});
        drain();
    endtask

    task automatic test_extremes;
        // full grid, extreme steps, strongest negative stagger, every mode bit
        load_grid(1024, 1024, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h300, 4'hf);
        send_index(0);
        send_index({IDX_W{1'b1}});
        send_index(1023);
        send_index(1024);
        send_index(1025);
        send_index(20'h55555);
        send_index(20'haaaaa);
        drain();
        // zero dimension read as one, oversized one clamped, stagger beyond limit
        load_grid(0, 2047, 5, 7, -3, 11, 32'h1ff, 4'h6);
        send_index(0);
        send_index(3);
        send_index(2047);
        send_index({IDX_W{1'b1}});
        drain();
        // stagger of magnitude one is off, serpentine vertical first, centred
        load_grid(3, 5, 100, -100, 7, -7, 32'h3ff, 4'ha);
        send_index(0);
        send_index(4);
        send_index(5);
        send_index(14);
        send_index(15);
        send_index(99);
        drain();
        load_grid(4, 3, 1001, 333, 1, -1, 3, 4'h1);
        for (int i = 0; i < 6; i++) send_index(IDX_W'(i));
        drain();
    endtask

    task automatic random_phase(int words);
        logic [DAT_W-1:0] cols, rws;
        if ($urandom_range(9) == 0) begin
            cols = $urandom_range(2047);
            rws  = $urandom_range(2047);
        end else begin
            cols = $urandom_range(1, 24);
            rws  = $urandom_range(1, 24);
        end
        load_grid(cols, rws, pick_step(), pick_step(), pick_step(), pick_step(),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(20) - 10,
                  $urandom_range(15));
        for (int i = 0; i < words; i++) send_index(pick_index());
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 12; ph++) random_phase(100);
    endtask

    task automatic test_steady_stream;
        steady = 1'b1;
        random_phase(150);
        steady = 1'b0;
    endtask

    task automatic test_backpressure;
        load_grid(7, 9, 40, -25, 3, 2, -5, 4'h5);
        hold_req = 1'b1;
        for (int i = 0; i < 120; i++) send_index(pick_index());
        drain();
    endtask

    // result side: random stalls plus one long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt == 0) begin
            hold_req = 1'b0;
            hold_cnt <= 250;
            m_ready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= (hold_cnt == 1);
        end else begin
            m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    always @(posedge aclk) begin
        offset_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_offsets.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d", $time, m_offset_x,
                         m_offset_y);
                errors++;
            end else begin
                want = pending_offsets.pop_front();
                if (want.x !== m_offset_x) begin
                    $display("%0t: offset_x expected %0d actual %0d", $time,
                             want.x, m_offset_x);
                    errors++;
                end
                if (want.y !== m_offset_y) begin
                    $display("%0t: offset_y expected %0d actual %0d", $time,
                             want.y, m_offset_y);
                    errors++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (s_valid || pending_offsets.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress, %0d words outstanding", $time,
                         pending_offsets.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_item_index = '0;
        words_sent = 0; phases_run = 0;
        steady = 1'b0; hold_req = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_extremes();
        test_steady_stream();
        test_backpressure();
        test_random();
        $display("covered %0d index words, %0d offsets checked, %0d register settings",
                 words_sent, words_checked, phases_run);
        $display("incl. clamped dims, stagger limits, all mode flags, long output stall");
        if (errors == 0 && pending_offsets.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
